@@ rtl/core/prc_pkg.sv @@
// prc_pkg: shared types, codes and default rule table for the packet rule classifier.
// Used by prc_cell and packet_rule_classifier.
package prc_pkg;

  localparam int unsigned DefRuleSlots = 128;
  localparam int unsigned DefLogDepth  = 512;
  localparam int unsigned NumDefaults  = 4;
  localparam int unsigned GrpSize      = 16;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  typedef enum logic [1:0] {
    FuncInspect = 2'd0,
    FuncAdd     = 2'd1,
    FuncClear   = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ActAllow = 2'd0,
    ActAlert = 2'd1,
    ActBlock = 2'd2,
    ActRsvd  = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    StIdle,
    StCmp,
    StPri,
    StSel,
    StOut
  } state_e;

  typedef struct packed {
    logic [31:0] smask;
    logic [31:0] dmask;
    logic [15:0] port;
    logic [7:0]  proto;
    logic [1:0]  action;
  } rule_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] port;
    logic [7:0]  proto;
  } key_t;

  // control broadcast to the cell row
  typedef struct packed {
    logic load_def;
    logic wr;
    logic cmp;
    logic bump;
  } cell_ctl_t;

  function automatic rule_t default_rule(input int unsigned idx);
    rule_t r;
    r = '0;
    case (idx)
      0: begin r.port = 16'd22;   r.proto = ProtoTcp;  r.action = ActAlert; end
      1: begin r.port = 16'd4444; r.proto = ProtoTcp;  r.action = ActBlock; end
      2: begin r.port = 16'd6667; r.proto = ProtoTcp;  r.action = ActBlock; end
      default: begin r.port = 16'd0; r.proto = ProtoIcmp; r.action = ActAlert; end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/prc_cell.sv @@
// prc_cell: one rule slot with its hit counter and match flag.
// Depends on prc_pkg.
module prc_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned IW  = 7,
  parameter int unsigned TW  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prc_pkg::cell_ctl_t ctl_i,
  input  logic [IW-1:0]      sel_i,
  input  logic [TW-1:0]      total_i,
  input  prc_pkg::rule_t     rule_i,
  input  prc_pkg::key_t      key_i,
  output prc_pkg::rule_t     rule_o,
  output logic [31:0]        hits_o,
  output logic               match_o
);
  import prc_pkg::*;

  rule_t       rule_q;
  logic [31:0] hits_q;
  logic        match_q;
  logic        mine, valid, hit;

  assign mine  = (sel_i == IW'(Idx));
  assign valid = (TW'(Idx) < total_i);

  assign hit = valid &&
    (rule_q.proto == '0 || rule_q.proto == key_i.proto) &&
    (rule_q.port == '0 || rule_q.port == key_i.port) &&
    ((key_i.src_ip & rule_q.smask) == rule_q.smask) &&
    ((key_i.dst_ip & rule_q.dmask) == rule_q.dmask);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_def && Idx < NumDefaults) begin
      rule_q <= default_rule(Idx);
      hits_q <= '0;
    end else if (ctl_i.wr && mine) begin
      rule_q <= rule_i;
      hits_q <= '0;
    end else if (ctl_i.bump && mine) begin
      hits_q <= hits_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      match_q <= hit;
    end
  end

  assign rule_o  = rule_q;
  assign hits_o  = hits_q;
  assign match_o = match_q;
endmodule

@@ rtl/core/packet_rule_classifier.sv @@
// Inspect results pass through compare, group priority, final select and the output register
// in that order; add, clear and unused codes go straight to the output register.
// One transaction is in flight, so a new item is taken only after the last has left the
// output state; a result stalled in the output register holds the block in its output state.
// Reset: asynchronous active low; control cleared, and while init_q is set the four default
// rules load before any item (reset restores rule count 4 and zero totals).
// Depends on prc_pkg and prc_cell.
module packet_rule_classifier #(
  parameter int unsigned RULE_SLOTS = prc_pkg::DefRuleSlots,
  parameter int unsigned LOG_DEPTH  = prc_pkg::DefLogDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_ip, dst_ip, port, proto, source mask, destination mask, rule_action, zero pad
  input  logic [159:0] s_axis_tdata,
  // func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // verdict, matched, rule_index, rule_hits, accepted, rules_loaded,
  // alert_total, block_total, logged_events, zero pad
  output logic [127:0] m_axis_tdata
);
  import prc_pkg::*;

  localparam int unsigned IW   = $clog2(RULE_SLOTS);
  localparam int unsigned TW   = $clog2(RULE_SLOTS + 1);
  localparam int unsigned EW   = $clog2(LOG_DEPTH + 1);
  localparam int unsigned NGRP = (RULE_SLOTS + GrpSize - 1) / GrpSize;
  localparam int unsigned OW   = $clog2(GrpSize);

  state_e state_q, state_d;

  logic [1:0]   func_q;
  key_t         key_q;
  rule_t        new_q;
  logic         init_q;

  logic [TW-1:0] total_q;
  logic [31:0]   alert_q, block_q;
  logic [EW-1:0] event_q;

  logic [NGRP-1:0] gany_q, gany_d;
  logic [OW-1:0]   goff_q [NGRP];
  logic [OW-1:0]   goff_d [NGRP];
  logic            found_q;
  logic [IW-1:0]   win_q, win_d;

  rule_t       rules_w [RULE_SLOTS];
  logic [31:0] hits_w  [RULE_SLOTS];
  logic        match_w [RULE_SLOTS];

  cell_ctl_t   ctl;
  logic [IW-1:0] sel;
  logic        out_free, do_out, is_clear;
  logic [7:0]  in_proto;
  logic [1:0]  in_act;

  logic        ovalid_q;
  logic [127:0] odata_q;

  assign out_free = !ovalid_q || m_axis_tready;
  assign do_out   = (state_q == StOut) && out_free;
  assign is_clear = (func_q == FuncClear);

  // cell row
  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
    prc_cell #(.Idx(i), .IW(IW), .TW(TW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sel_i   (sel),
      .total_i (total_q),
      .rule_i  (new_q),
      .key_i   (key_q),
      .rule_o  (rules_w[i]),
      .hits_o  (hits_w[i]),
      .match_o (match_w[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (s_axis_tvalid && s_axis_tready) begin
        state_d = (func_e'(s_axis_tuser) == FuncInspect) ? StCmp : StOut;
      end
      StCmp:  state_d = StPri;
      StPri:  state_d = StSel;
      StSel:  state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs to the row
  always_comb begin
    ctl.load_def = init_q || (do_out && is_clear);
    ctl.wr       = do_out && (func_q == FuncAdd) && (total_q < TW'(RULE_SLOTS));
    ctl.cmp      = (state_q == StCmp);
    ctl.bump     = do_out && (func_q == FuncInspect) && found_q;
    sel          = (func_q == FuncAdd) ? IW'(total_q) : win_q;
  end

  // lowest matching cell inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      gany_d[g] = 1'b0;
      goff_d[g] = '0;
      for (int k = GrpSize - 1; k >= 0; k--) begin
        if (g * GrpSize + k < RULE_SLOTS) begin
          if (match_w[g * GrpSize + k]) begin
            gany_d[g] = 1'b1;
            goff_d[g] = OW'(k);
          end
        end
      end
    end
  end

  // lowest group with a match
  always_comb begin
    win_d = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (gany_q[g]) win_d = IW'(g * GrpSize + int'(goff_q[g]));
    end
  end

  assign s_axis_tready = (state_q == StIdle) && !init_q;

  assign in_proto = s_axis_tdata[87:80];
  assign in_act   = s_axis_tdata[153:152];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      init_q  <= 1'b1;
      total_q <= TW'(NumDefaults);
      alert_q <= '0;
      block_q <= '0;
      event_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= 1'b0;
      if (do_out) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      if (do_out) begin
        if (is_clear) begin
          total_q <= TW'(NumDefaults);
          alert_q <= '0;
          block_q <= '0;
          event_q <= '0;
        end else if (ctl.wr) begin
          total_q <= total_q + TW'(1);
        end else if (ctl.bump) begin
          if (event_q < EW'(LOG_DEPTH)) event_q <= event_q + EW'(1);
          if (rules_w[win_q].action == ActAlert) alert_q <= alert_q + 32'd1;
          if (rules_w[win_q].action == ActBlock) block_q <= block_q + 32'd1;
        end
      end
    end
  end

  // input capture, priority stages and result register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q        <= s_axis_tuser;
      key_q.src_ip  <= s_axis_tdata[31:0];
      key_q.dst_ip  <= s_axis_tdata[63:32];
      key_q.port    <= s_axis_tdata[79:64];
      key_q.proto   <= (in_proto == ProtoTcp || in_proto == ProtoUdp) ? in_proto : ProtoIcmp;
      new_q.port     <= s_axis_tdata[79:64];
      new_q.proto    <= in_proto;
      new_q.smask    <= s_axis_tdata[119:88];
      new_q.dmask    <= s_axis_tdata[151:120];
      new_q.action   <= (in_act == ActRsvd) ? ActAllow : in_act;
      found_q        <= 1'b0;
      win_q          <= '0;
    end
    if (state_q == StPri) begin
      gany_q <= gany_d;
      goff_q <= goff_d;
    end
    if (state_q == StSel) begin
      found_q <= |gany_q;
      win_q   <= win_d;
    end
    if (do_out) begin
      odata_q[127:125] <= '0;
      odata_q[1:0]     <= (ctl.bump) ? rules_w[win_q].action : ActAllow;
      odata_q[2]       <= ctl.bump;
      odata_q[9:3]     <= ctl.bump ? 7'(win_q) : 7'd0;
      odata_q[41:10]   <= ctl.bump ? hits_w[win_q] + 32'd1 : 32'd0;
      odata_q[42]      <= (func_q == FuncAdd) ? ctl.wr : 1'b1;
      odata_q[50:43]   <= is_clear ? 8'(NumDefaults) : 8'(total_q + (ctl.wr ? TW'(1) : TW'(0)));
      odata_q[82:51]   <= is_clear ? 32'd0 :
                          alert_q + ((ctl.bump && rules_w[win_q].action == ActAlert) ? 32'd1 : 32'd0);
      odata_q[114:83]  <= is_clear ? 32'd0 :
                          block_q + ((ctl.bump && rules_w[win_q].action == ActBlock) ? 32'd1 : 32'd0);
      odata_q[124:115] <= is_clear ? 10'd0 :
                          10'((ctl.bump && event_q < EW'(LOG_DEPTH)) ? event_q + EW'(1) : event_q);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(RULE_SLOTS)) else $error("rule count over capacity");
  a_event_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_q <= EW'(LOG_DEPTH)) else $error("event count over log depth");
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == StOut)) else $error("result without item");
`endif
endmodule

@@ tb/tb_packet_rule_classifier.sv @@
// Testbench for packet_rule_classifier: drives rule adds, inspects and clears over the
// stream ports and checks every result against a behavioral rule-table predictor.
// Depends on prc_pkg and the packet_rule_classifier RTL.
module tb_packet_rule_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import prc_pkg::*;

  localparam int unsigned Slots    = 128;
  localparam int unsigned LogDepth = 512;
  localparam int unsigned MaxCycles = 400000;

  typedef struct packed {
    logic [9:0]  logged_events;
    logic [31:0] block_total;
    logic [31:0] alert_total;
    logic [7:0]  rules_loaded;
    logic        accepted;
    logic [31:0] rule_hits;
    logic [6:0]  rule_index;
    logic        matched;
    logic [1:0]  verdict;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  packet_rule_classifier dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] tbl_smask [Slots];
  logic [31:0] tbl_dmask [Slots];
  logic [15:0] tbl_port [Slots];
  logic [7:0]  tbl_proto [Slots];
  logic [1:0]  tbl_act [Slots];
  logic [31:0] tbl_hits [Slots];
  int unsigned tbl_count;
  logic [31:0] alerts, blocks;
  int unsigned events;

  verdict_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;

  function automatic void table_append(logic [31:0] sm, logic [31:0] dm, logic [15:0] pt,
                                       logic [7:0] pr, logic [1:0] ac);
    tbl_smask[tbl_count] = sm;
    tbl_dmask[tbl_count] = dm;
    tbl_port[tbl_count]  = pt;
    tbl_proto[tbl_count] = pr;
    tbl_act[tbl_count]   = (ac == ActRsvd) ? ActAllow : ac;
    tbl_hits[tbl_count]  = '0;
    tbl_count++;
  endfunction

  function automatic void table_defaults();
    tbl_count = 0;
    alerts = '0;
    blocks = '0;
    events = 0;
    table_append('0, '0, 16'd22, ProtoTcp, ActAlert);
    table_append('0, '0, 16'd4444, ProtoTcp, ActBlock);
    table_append('0, '0, 16'd6667, ProtoTcp, ActBlock);
    table_append('0, '0, 16'd0, ProtoIcmp, ActAlert);
  endfunction

  function automatic verdict_t classify(func_e fn, logic [31:0] sip, logic [31:0] dip,
                                        logic [15:0] pt, logic [7:0] pr, logic [31:0] sm,
                                        logic [31:0] dm, logic [1:0] ac);
    verdict_t r;
    logic [7:0] p;
    r = '0;
    r.accepted = 1'b1;
    case (fn)
      FuncInspect: begin
        p = (pr == ProtoTcp || pr == ProtoUdp) ? pr : ProtoIcmp;
        for (int i = 0; i < tbl_count; i++) begin
          if ((tbl_proto[i] == 0 || tbl_proto[i] == p) &&
              (tbl_port[i] == 0 || tbl_port[i] == pt) &&
              (tbl_smask[i] == 0 || (sip & tbl_smask[i]) == tbl_smask[i]) &&
              (tbl_dmask[i] == 0 || (dip & tbl_dmask[i]) == tbl_dmask[i])) begin
            tbl_hits[i]++;
            if (events < LogDepth) events++;
            r.verdict = tbl_act[i];
            if (tbl_act[i] == ActAlert) alerts++;
            else if (tbl_act[i] == ActBlock) blocks++;
            r.matched = 1'b1;
            r.rule_index = i[6:0];
            r.rule_hits = tbl_hits[i];
            break;
          end
        end
      end
      FuncAdd: begin
        if (tbl_count >= Slots) r.accepted = 1'b0;
        else table_append(sm, dm, pt, pr, ac);
      end
      FuncClear: table_defaults();
      default: ;
    endcase
    r.rules_loaded = tbl_count[7:0];
    r.alert_total = alerts;
    r.block_total = blocks;
    r.logged_events = events[9:0];
    return r;
  endfunction

  // one transaction on the input side, with optional random gap first
  task automatic send_item(func_e fn, logic [31:0] sip, logic [31:0] dip, logic [15:0] pt,
                           logic [7:0] pr, logic [31:0] sm, logic [31:0] dm, logic [1:0] ac);
    if (!quiet && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk_i);
    end
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {6'b0, ac, dm, sm, pr, pt, dip, sip};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(classify(fn, sip, dip, pt, pr, sm, dm, ac));
    @(negedge clk_i);
  endtask

  task automatic add_rule(logic [31:0] sm, logic [31:0] dm, logic [15:0] pt, logic [7:0] pr,
                          logic [1:0] ac);
    send_item(FuncAdd, $urandom, $urandom, pt, pr, sm, dm, ac);
  endtask

  task automatic inspect(logic [31:0] sip, logic [31:0] dip, logic [15:0] pt, logic [7:0] pr);
    send_item(FuncInspect, sip, dip, pt, pr, $urandom, $urandom, 2'($urandom));
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(4))
      0: return ProtoTcp;
      1: return ProtoUdp;
      2: return ProtoIcmp;
      3: return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(3))
      0: return '0;
      1: return 32'hFFFF_FFFF << $urandom_range(32, 8);
      2: return 32'(1) << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_defaults();
    inspect(32'h0A00_0001, 32'hC0A8_0001, 16'd22, ProtoTcp);
    inspect('0, '0, 16'd4444, ProtoTcp);
    inspect('1, '1, 16'd6667, ProtoTcp);
    inspect('1, '0, 16'hFFFF, 8'hFF);     // odd protocol maps to ICMP
    inspect('0, '1, 16'd22, ProtoUdp);    // no match
    inspect('0, '0, 16'd0, ProtoIcmp);
    send_item(FuncNone, '1, '1, 16'd22, ProtoTcp, '1, '1, ActBlock);
  endtask

  task automatic test_rules();
    add_rule(32'hFFFF_0000, 32'h0000_00FF, 16'd80, ProtoUdp, ActAllow);
    add_rule('1, '1, 16'hFFFF, 8'd0, ActRsvd);      // action three stored as allow
    add_rule('0, '0, 16'd53, 8'd99, ActBlock);       // protocol that never matches
    inspect(32'hFFFF_1234, 32'h0000_00FF, 16'd80, ProtoUdp);
    inspect('1, '1, 16'hFFFF, ProtoUdp);
    inspect('0, '0, 16'd53, 8'd99);
    send_item(FuncClear, '0, '0, '0, '0, '0, '0, ActAllow);
    inspect('0, '0, 16'd22, ProtoTcp);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < Slots - 4 + 2; i++)
      add_rule(pick_mask(), pick_mask(), 16'($urandom_range(3)), pick_proto(),
               2'($urandom_range(3)));
    repeat (60)
      inspect($urandom, $urandom, 16'($urandom_range(3)), pick_proto());
    send_item(FuncClear, '0, '0, '0, '0, '0, '0, ActAllow);
  endtask

  task automatic test_random(int unsigned n);
    logic [31:0] sm, dm;
    for (int i = 0; i < n; i++) begin
      if (i > n - 80) quiet = 1'b1;
      case ($urandom_range(19))
        0: send_item(FuncClear, $urandom, $urandom, 16'($urandom), 8'($urandom),
                     $urandom, $urandom, 2'($urandom));
        1: send_item(FuncNone, $urandom, $urandom, 16'($urandom), 8'($urandom),
                     $urandom, $urandom, 2'($urandom));
        2, 3, 4: add_rule(pick_mask(), pick_mask(),
                          ($urandom_range(1) ? 16'($urandom_range(5)) : 16'($urandom)),
                          pick_proto(), 2'($urandom));
        default: begin
          // aim packets at existing rules to get deep matches
          if (tbl_count > 0 && $urandom_range(2) != 0) begin
            int unsigned k;
            k = $urandom_range(tbl_count - 1);
            sm = tbl_smask[k];
            dm = tbl_dmask[k];
            inspect($urandom | sm, $urandom | dm,
                    (tbl_port[k] != 0) ? tbl_port[k] : 16'($urandom),
                    (tbl_proto[k] == 0) ? 8'($urandom) : tbl_proto[k]);
          end else begin
            inspect($urandom, $urandom, 16'($urandom_range(6700)), 8'($urandom));
          end
        end
      endcase
    end
  endtask

  // output side: random stall bursts, quiet toward the end
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(12, 1)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    verdict_t got, exp;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(verdict_t)-1:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", exp, got);
        end
      end
    end
    if (cycles > MaxCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    table_defaults();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_rules();
    test_full_table();
    test_random(300);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/prc_pkg.sv
rtl/core/prc_cell.sv
rtl/core/packet_rule_classifier.sv
tb/tb_packet_rule_classifier.sv
